// ===== rtl/core/sigact_pkg.sv =====
package sigact_pkg;

    localparam int XW = 16;
    localparam int IW = 12;
    localparam int YW = 12;
    localparam int GW = 11;
    localparam int ROM_DEPTH = 4096;
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 8;

    localparam logic signed [XW-1:0] X_MIN = -16'sd2048;
    localparam logic signed [XW-1:0] X_MAX = 16'sd2047;

    typedef enum logic {
        MODE_FWD = 1'b0,
        MODE_BWD = 1'b1
    } sig_mode_t;

    typedef struct packed {
        sig_mode_t              mode;
        logic                   in_range;
        logic [IW-1:0]          index;
        logic [YW-1:0]          rom_idx;
        logic signed [XW-1:0]   dout;
    } sig_item_t;

    typedef logic [ROM_DEPTH-1:0][YW-1:0] sig_rom_t;

    // shift-subtract quotient of n by d, quotient known to fit in qbits bits
    function automatic logic [63:0] rom_udiv(logic [63:0] n, logic [63:0] d, int qbits);
        logic [63:0] r;
        logic [63:0] q;
        int          b;
        r = n;
        q = '0;
        for (b = qbits - 1; b >= 0; b--)
        begin
            if (r >= (d << b))
            begin
                r = r - (d << b);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid in Q0.12 over clamped x = -2048..2047 (Q8.8), entry i is x = i - 2048
    function automatic sig_rom_t build_sig_rom();
        sig_rom_t    t;
        int          i;
        int          k;
        int          xs;
        logic [63:0] one;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] y;
        one = 64'd1 << 32;
        for (i = 0; i < ROM_DEPTH; i++)
        begin
            xs = i - 2048;
            a = 64'((xs < 0) ? -xs : xs);
            term = one;
            e = one;
            for (k = 1; k <= 80; k++)
            begin
                if (term != 64'd0)
                begin
                    // series terms stay below 2^44
                    term = rom_udiv(term * a, 64'd256 * 64'(k), 44);
                    e = e + term;
                end
            end
            den = e + one;
            if (xs >= 0)
                num = 64'd8192 * e;
            else
                num = 64'd8192 * one;
            y = rom_udiv(num + den, 64'd2 * den, 13);
            if (y > 64'd4095)
                y = 64'd4095;
            t[i] = y[YW-1:0];
        end
        return t;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== rtl/core/sigact_ram.sv =====
module sigact_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sigact_fifo.sv =====
module sigact_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               wdata,
    output logic                           full,
    input  logic                           pop,
    output logic [WIDTH-1:0]               rdata,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full = (count_reg == CW'(DEPTH));
        empty = (count_reg == '0);
        do_push = push && !full;
        do_pop = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== rtl/core/sigact_front.sv =====
module sigact_front import sigact_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 mode,
    input  logic [IW-1:0]        index,
    input  logic signed [XW-1:0] value,
    output logic                 q_push,
    output sig_item_t            q_item,
    input  logic                 q_full
);

    localparam logic [16:0] LIMIT = 17'(MAX_ELEMENTS);

    logic                 f_valid_reg, f_valid_next;
    sig_item_t            f_item_reg, f_item_next;
    logic                 take;
    logic signed [XW-1:0] clamped;

    always_comb
    begin
        full = f_valid_reg && q_full;
        take = push && !full;
        if (value < X_MIN)
            clamped = X_MIN;
        else if (value > X_MAX)
            clamped = X_MAX;
        else
            clamped = value;
        f_item_next.mode = sig_mode_t'(mode);
        f_item_next.in_range = ({5'd0, index} < LIMIT);
        f_item_next.index = index;
        // offset by half range: flip the sign bit of the 12-bit clamped value
        f_item_next.rom_idx = clamped[YW-1:0] ^ {1'b1, {(YW-1){1'b0}}};
        f_item_next.dout = value;
        f_valid_next = take || (f_valid_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            f_item_reg <= f_item_next;
    end

    assign q_push = f_valid_reg && !q_full;
    assign q_item = f_item_reg;

endmodule

// ===== rtl/core/sigact_back.sv =====
module sigact_back import sigact_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int ODEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  sig_item_t                      q_item,
    output logic                           q_pop,
    input  logic [$clog2(ODEPTH+1)-1:0]    out_count,
    output logic                           out_push,
    output logic [XW-1:0]                  out_result
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int OCW = $clog2(ODEPTH + 1) + 1;

    logic                 issue;
    logic [OCW-1:0]       occupancy;

    logic                 p1_valid_reg, p1_valid_next;
    sig_item_t            p1_item_reg;
    logic [YW-1:0]        p1_y_rom_reg;
    logic [YW-1:0]        ram_q;
    logic                 ram_we;
    logic                 bypass;
    logic [YW-1:0]        y_bwd;
    logic [24:0]          gprod;

    logic                 p2_valid_reg, p2_valid_next;
    sig_item_t            p2_item_reg;
    logic [YW-1:0]        p2_y_reg;
    logic [GW-1:0]        p2_g_reg, p2_g_next;
    logic signed [27:0]   prod;
    logic [XW-1:0]        result_next;

    logic                 p3_valid_reg, p3_valid_next;
    logic [XW-1:0]        p3_result_reg;

    // issue only with a guaranteed slot in the output queue
    always_comb
    begin
        occupancy = OCW'(out_count) + OCW'(p1_valid_reg) + OCW'(p2_valid_reg)
            + OCW'(p3_valid_reg);
        issue = !q_empty && (occupancy < OCW'(ODEPTH));
        p1_valid_next = issue;
        p2_valid_next = p1_valid_reg;
        p3_valid_next = p2_valid_reg;
    end

    assign q_pop = issue;
    assign ram_we = p1_valid_reg && (p1_item_reg.mode == MODE_FWD) && p1_item_reg.in_range;

    sigact_ram #(
        .WIDTH (YW),
        .DEPTH (MAX_ELEMENTS)
    ) u_act_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(p1_item_reg.index)),
        .wdata (p1_y_rom_reg),
        .re    (issue),
        .raddr (AW'(q_item.index)),
        .rdata (ram_q)
    );

    // stage 1: stored y (with forwarding from the preceding word's write), derivative
    always_comb
    begin
        bypass = p2_valid_reg && (p2_item_reg.mode == MODE_FWD) && p2_item_reg.in_range
            && (p2_item_reg.index == p1_item_reg.index);
        if (!p1_item_reg.in_range)
            y_bwd = '0;
        else if (bypass)
            y_bwd = p2_y_reg;
        else
            y_bwd = ram_q;
        gprod = 25'(y_bwd) * (25'(13'h1000) - 25'(y_bwd));
        p2_g_next = gprod[22:12];
    end

    // stage 2: y for forward words, dx = floor(dout * g / 4096) for backward ones
    always_comb
    begin
        prod = 28'(p2_item_reg.dout) * 28'(signed'({1'b0, p2_g_reg}));
        case (p2_item_reg.mode)
            MODE_FWD: result_next = {{(XW-YW){1'b0}}, p2_y_reg};
            MODE_BWD: result_next = prod[27:12];
            default:  result_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            p3_valid_reg <= p3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_item_reg <= q_item;
            p1_y_rom_reg <= SIG_ROM[q_item.rom_idx];
        end
        if (p1_valid_reg)
        begin
            p2_item_reg <= p1_item_reg;
            p2_y_reg <= p1_y_rom_reg;
            p2_g_reg <= p2_g_next;
        end
        if (p2_valid_reg)
            p3_result_reg <= result_next;
    end

    assign out_push = p3_valid_reg;
    assign out_result = p3_result_reg;

endmodule

// ===== rtl/core/sigmoid_activation_fwd_bwd.sv =====
// Sigmoid element engine, forward and backward. A forward word (mode 0) clamps x (Q8.8) to
// [-8, 8), looks up y = sigmoid(x) in Q0.12, saves y at the index and returns it. A backward
// word (mode 1) reads the saved y at the index and returns
// floor(dout * floor(y * (4096 - y) / 4096) / 4096) in Q8.8. One word is accepted per clock
// unless full, and one result leaves per clock while popped; the figure is set by the
// activation memory, which takes one read and one write each cycle. From push a word passes
// an input register, a two-entry queue, three back-end stages (table and memory read,
// derivative, gradient multiply) and then the result queue. Backward reads of an entry that
// no forward word has written return an undefined value. Indexes at or beyond MAX_ELEMENTS
// are not stored; a backward word there returns 0. Results come out in input order.
module sigmoid_activation_fwd_bwd import sigact_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 mode,
    input  logic [IW-1:0]        index,
    input  logic signed [XW-1:0] value,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [XW-1:0] result
);

    localparam int IBITS = $bits(sig_item_t);

    logic                            mid_push;
    sig_item_t                       mid_wdata;
    logic                            mid_full;
    logic                            mid_pop;
    logic [IBITS-1:0]                mid_rdata;
    logic                            mid_empty;
    logic [$clog2(MID_DEPTH+1)-1:0]  mid_count;
    logic                            out_push;
    logic [XW-1:0]                   out_wdata;
    logic [XW-1:0]                   out_rdata;
    logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;
    logic                            out_full;

    sigact_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .mode   (mode),
        .index  (index),
        .value  (value),
        .q_push (mid_push),
        .q_item (mid_wdata),
        .q_full (mid_full)
    );

    sigact_fifo #(
        .WIDTH (IBITS),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    sigact_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ODEPTH       (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (mid_empty),
        .q_item     (sig_item_t'(mid_rdata)),
        .q_pop      (mid_pop),
        .out_count  (out_count),
        .out_push   (out_push),
        .out_result (out_wdata)
    );

    sigact_fifo #(
        .WIDTH (XW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push && !out_full),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign result = signed'(out_rdata) | XW'(mid_count & '0);

endmodule

// ===== rtl/core/sigact_checker.sv =====
module sigact_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [15:0] result
);

    logic [4:0] pending_reg, pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if ((push && !full) && !(pop && !empty))
            pending_next = pending_reg + 1'b1;
        else if (!(push && !full) && (pop && !empty))
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // no result word without an accepted input word behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_reg != 5'd0))
        else $error("result word with nothing outstanding");

    // with nothing outstanding the input side must be open
    a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 5'd0) |-> !full)
        else $error("full while idle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result word withdrawn");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("result word changed while stalled");

endmodule

bind sigmoid_activation_fwd_bwd sigact_checker u_sigact_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sigact_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ACT_DEPTH = 4096;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 mode = MODE_FWD;
    logic [IW-1:0]        index = '0;
    logic signed [XW-1:0] value = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [XW-1:0] result;

    logic [YW-1:0]        sigmoid_lut [ACT_DEPTH];
    logic [YW-1:0]        act_mem [ACT_DEPTH];
    bit                   act_written [ACT_DEPTH];
    int                   written_list [$];
    logic signed [XW-1:0] expected_results [$];

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycles = 0;
    int words_seen = 0;

    sigmoid_activation_fwd_bwd #(.MAX_ELEMENTS(ACT_DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .mode  (mode),
        .index (index),
        .value (value),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // round(4096 / (1 + exp(-x))), x in Q8.8, exp by Taylor series in Q32.32
    function automatic logic [YW-1:0] calc_sigmoid(int xs);
        longint unsigned unity;
        longint unsigned mag;
        longint unsigned term;
        longint unsigned ex;
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        int              k;
        unity = 64'd1 << 32;
        mag = (xs < 0) ? longint'(-xs) : longint'(xs);
        term = unity;
        ex = unity;
        for (k = 1; k <= 80; k++)
        begin
            term = (term * mag) / (64'd256 * longint'(k));
            if (term == 0)
                break;
            ex = ex + term;
        end
        den = ex + unity;
        num = (xs >= 0) ? 64'd8192 * ex : 64'd8192 * unity;
        q = (num + den) / (64'd2 * den);
        if (q > 64'd4095)
            q = 64'd4095;
        return q[YW-1:0];
    endfunction

    function automatic logic signed [XW-1:0] sigmoid_word(sig_mode_t m, logic [IW-1:0] idx,
                                                           logic signed [XW-1:0] v);
        int            xs;
        logic [YW-1:0] y;
        longint        g;
        longint        p;
        if (m == MODE_FWD)
        begin
            xs = v;
            if (xs < -2048)
                xs = -2048;
            if (xs > 2047)
                xs = 2047;
            y = sigmoid_lut[xs + 2048];
            act_mem[idx] = y;
            if (!act_written[idx])
            begin
                act_written[idx] = 1'b1;
                written_list.push_back(idx);
            end
            return {4'd0, y};
        end
        y = act_mem[idx];
        g = (longint'(y) * (4096 - longint'(y))) / 4096;
        p = longint'(v) * g;
        p = p >>> 12;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return p[XW-1:0];
    endfunction

    task automatic send_word(sig_mode_t m, logic [IW-1:0] idx, logic signed [XW-1:0] v);
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        mode <= m;
        index <= idx;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_results.push_back(sigmoid_word(m, idx, v));
        @(negedge clk);
    endtask

    task automatic send_random(int n);
        int                   i;
        int                   sel;
        logic [IW-1:0]        idx;
        logic signed [XW-1:0] v;
        for (i = 0; i < n; i++)
        begin
            if (written_list.size() == 0 || $urandom_range(1) == 0)
            begin
                idx = ($urandom_range(2) == 0) ? IW'($urandom_range(ACT_DEPTH - 1))
                                               : IW'($urandom_range(63));
                sel = $urandom_range(7);
                if (sel < 2)
                    v = XW'($urandom);
                else if (sel < 6)
                    v = XW'(int'($urandom_range(4095)) - 2048);
                else if (sel == 6)
                    v = XW'(int'($urandom_range(8)) - 2052);
                else
                    v = XW'(int'($urandom_range(8)) + 2043);
                send_word(MODE_FWD, idx, v);
            end
            else
            begin
                idx = IW'(written_list[$urandom_range(written_list.size() - 1)]);
                sel = $urandom_range(9);
                if (sel == 0)
                    v = 16'sh8000;
                else if (sel == 1)
                    v = 16'sh7fff;
                else
                    v = XW'($urandom);
                send_word(MODE_BWD, idx, v);
            end
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        gap_pct = 0;
        stall_pct = 0;
        send_word(MODE_FWD, 12'd0, 16'sh8000);
        send_word(MODE_FWD, 12'd4095, 16'sh7fff);
        send_word(MODE_FWD, 12'd1, 16'sd0);
        send_word(MODE_FWD, 12'd2, -16'sd2049);
        send_word(MODE_FWD, 12'd3, 16'sd2048);
        send_word(MODE_FWD, 12'd4, -16'sd2048);
        send_word(MODE_FWD, 12'd5, 16'sd2047);
        send_word(MODE_FWD, 12'd6, -16'sd1);
        send_word(MODE_FWD, 12'd7, 16'sd1);
        send_word(MODE_FWD, 12'd8, 16'sd256);
        send_word(MODE_BWD, 12'd1, 16'sh7fff);
        send_word(MODE_BWD, 12'd1, 16'sh8000);
        send_word(MODE_BWD, 12'd1, -16'sd1);
        send_word(MODE_BWD, 12'd1, 16'sd0);
        send_word(MODE_BWD, 12'd4095, 16'sh8000);
        send_word(MODE_BWD, 12'd0, 16'sh7fff);
        send_word(MODE_BWD, 12'd6, 16'sh8000);
        send_word(MODE_BWD, 12'd8, -16'sd777);
        send_word(MODE_FWD, 12'd1, -16'sd512);
        send_word(MODE_BWD, 12'd1, 16'sd1000);
        send_word(MODE_BWD, 12'd1, -16'sd1000);
        wait_drained();
    endtask

    task automatic test_random_phases();
        gap_pct = 0;
        stall_pct = 0;
        send_random(220);
        gap_pct = 51;
        send_random(220);
        gap_pct = 0;
        stall_pct = 51;
        send_random(220);
        gap_pct = 7;
        stall_pct = 7;
        send_random(220);
        gap_pct = 0;
        stall_pct = 0;
    endtask

    // long pop hold-off while words keep coming, so full must assert
    task automatic test_backpressure();
        gap_pct = 0;
        hold_left = 300;
        send_random(60);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        repeat (20) @(negedge clk);
        send_random(20);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < ACT_DEPTH; i++)
        begin
            sigmoid_lut[i] = calc_sigmoid(i - 2048);
            act_mem[i] = '0;
            act_written[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random_phases();
        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        logic signed [XW-1:0] exp_word;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                words_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %0d: result=%0d", words_seen, result);
                end
                else
                begin
                    exp_word = expected_results.pop_front();
                    if (result !== exp_word)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: result expected %0d got %0d",
                                     words_seen, exp_word, result);
                    end
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
